// ===== design/mmc3_multicart_bank_mapper_assert.svh =====
// Assertion macros for the multicart bank mapper.
// Used inside modules that have i_clk and i_rst_n in scope.
`ifndef MMC3_MULTICART_BANK_MAPPER_ASSERT_SVH
`define MMC3_MULTICART_BANK_MAPPER_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent.
`define MMC3MC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define MMC3MC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mmc3mc_pkg.sv =====
// Package for the multicart bank mapper: beat types, decode codes and
// bank number helpers. No dependencies.
`default_nettype none

package mmc3mc_pkg;

    // Command codes
    localparam logic CMD_CPU_WRITE = 1'b0;
    localparam logic CMD_LINE_TICK = 1'b1;

    // Register decode (address & mask)
    localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] ADDR_MIRRORING   = 16'hA000;
    localparam logic [15:0] ADDR_OUTER_BANK  = 16'hA001;
    localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF     = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON      = 16'hE001;

    // Bank select low three bits
    localparam logic [2:0] BANKSEL_LAST_PAIR   = 3'd1;
    localparam logic [2:0] BANKSEL_FIRST_SINGLE = 3'd2;
    localparam logic [2:0] BANKSEL_LAST_SINGLE = 3'd5;
    localparam logic [2:0] BANKSEL_PRG_FIRST   = 3'd6;

    localparam int unsigned BANK_SELECT_PRG_SWAP = 6;
    localparam int unsigned BANK_SELECT_CHR_SWAP = 7;

    localparam logic [2:0] OUTER_WIDE    = 3'd6;
    localparam logic [2:0] OUTER_INVALID = 3'd7;

    localparam logic [7:0] PRG_SECOND_LAST = 8'h1E;
    localparam logic [7:0] PRG_LAST        = 8'h1F;

    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    // Configuration register indexes
    typedef enum logic {
        CFG_CHR_ROM_PRESENT = 1'b0,
        CFG_FOUR_SCREEN     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        MIRROR_VERTICAL   = 2'd0,
        MIRROR_HORIZONTAL = 2'd1,
        MIRROR_FOUR       = 2'd2
    } t_mirroring;

    typedef struct packed {
        logic       command;
        logic [15:0] address;
        logic [7:0] data;
        logic [8:0] scanline;
        logic       rendering;
    } t_in_item;

    typedef struct packed {
        logic [27:0] prg_banks;
        logic [39:0] chr_banks_low;
        logic [39:0] chr_banks_high;
        logic [1:0]  mirroring;
        logic        irq_request;
    } t_result_item;

    typedef struct packed {
        t_cfg_index index;
        logic       data;
    } t_cfg_item;

    // 7-bit 8KB PRG bank number within the selected game
    function automatic logic [6:0] prg_number(input logic [7:0] inner,
                                              input logic [2:0] outer);
        logic [4:0] masked;
        masked = (outer == OUTER_WIDE) ? inner[4:0] : {1'b0, inner[3:0]};
        return {outer, 4'b0000} | {2'b00, masked};
    endfunction

    // 10-bit 1KB CHR bank number within the selected game
    function automatic logic [9:0] chr_number(input logic [7:0] inner,
                                              input logic [2:0] outer);
        logic [7:0] masked;
        masked = (outer == OUTER_WIDE) ? inner : {1'b0, inner[6:0]};
        return {outer, 7'b0000000} | {2'b00, masked};
    endfunction

endpackage

`default_nettype wire

// ===== design/mmc3mc_if.sv =====
// Handshake interfaces for the multicart bank mapper channels.
// Depends on mmc3mc_pkg for the beat types.
`default_nettype none

interface mmc3mc_item_if;
    import mmc3mc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mmc3mc_result_if;
    import mmc3mc_pkg::*;
    logic         valid;
    logic         ready;
    t_result_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mmc3mc_cfg_if;
    import mmc3mc_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    logic       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mmc3_multicart_bank_mapper.sv =====
// Multicart MMC3 bank mapper. Depends on mmc3mc_pkg, mmc3mc_if.sv and the
// assert macro header. Each input beat is either a CPU write (decoded by
// address & 0xE001: bank select, bank data, mirroring, outer game, IRQ count,
// IRQ reload, IRQ off, IRQ on) or an end-of-scanline tick that clocks the IRQ
// counter on visible lines with rendering on and the IRQ enabled. Every input
// beat yields exactly one result beat with the four PRG and eight CHR bank
// numbers, mirroring and the IRQ pulse, all reflecting the state after that
// beat. The result is registered: the register update and the bank mapping
// are one short level of logic feeding the result register, and a new beat is
// taken every cycle as long as the result register is empty or being drained in
// the same cycle. The configuration port is always ready; write it only while idle.
`default_nettype none
`include "mmc3_multicart_bank_mapper_assert.svh"

module mmc3_multicart_bank_mapper
    import mmc3mc_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    mmc3mc_cfg_if.sink     i_cfg,
    mmc3mc_item_if.sink    i_in,
    mmc3mc_result_if.source o_out
);

    // Configuration
    logic r_chr_rom_present;
    logic r_four_screen;

    // Mapper state
    logic [7:0] r_bank_select,  n_bank_select;
    logic [2:0] r_outer_bank,   n_outer_bank;
    logic [7:0] r_prg_first,    n_prg_first;
    logic [7:0] r_prg_second,   n_prg_second;
    logic [7:0] r_chr_pair   [2];
    logic [7:0] n_chr_pair   [2];
    logic [7:0] r_chr_single [4];
    logic [7:0] n_chr_single [4];
    logic [7:0] r_irq_count,    n_irq_count;
    logic [7:0] r_irq_reload,   n_irq_reload;
    logic       r_irq_on,       n_irq_on;
    logic       r_mirror_h,     n_mirror_h;
    logic       n_irq;

    // Result register
    logic         r_out_valid;
    t_result_item r_out,        n_out;

    logic       w_in_acc;
    logic [2:0] w_sel;
    logic [1:0] w_single_idx;
    logic [2:0] w_single_off;
    logic [15:0] w_decode;
    logic       w_tick_counts;

    // Skid-free output stage: accept when empty or draining this cycle
    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign w_in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
    assign i_cfg.ready   = 1'b1;

    assign w_sel        = r_bank_select[2:0];
    assign w_single_off = w_sel - BANKSEL_FIRST_SINGLE;
    assign w_single_idx = w_single_off[1:0];
    assign w_decode     = i_in.payload.address & ADDR_DECODE_MASK;
    assign w_tick_counts = r_irq_on && i_in.payload.rendering
                           && (i_in.payload.scanline <= LAST_VISIBLE_LINE);

    // Next-state: CPU register writes and the scanline IRQ counter
    always_comb begin
        n_bank_select = r_bank_select;
        n_outer_bank  = r_outer_bank;
        n_prg_first   = r_prg_first;
        n_prg_second  = r_prg_second;
        n_chr_pair    = r_chr_pair;
        n_chr_single  = r_chr_single;
        n_irq_count   = r_irq_count;
        n_irq_reload  = r_irq_reload;
        n_irq_on      = r_irq_on;
        n_mirror_h    = r_mirror_h;
        n_irq         = 1'b0;
        if (w_in_acc) begin
            if (i_in.payload.command == CMD_CPU_WRITE) begin
                unique case (w_decode)
                    ADDR_BANK_SELECT: n_bank_select = i_in.payload.data;
                    ADDR_BANK_DATA: begin
                        priority if (w_sel <= BANKSEL_LAST_PAIR) begin
                            if (r_chr_rom_present) begin
                                // 2KB pair: even bank only
                                n_chr_pair[w_sel[0]] = {i_in.payload.data[7:1], 1'b0};
                            end
                        end else if (w_sel <= BANKSEL_LAST_SINGLE) begin
                            if (r_chr_rom_present) begin
                                n_chr_single[w_single_idx] = i_in.payload.data;
                            end
                        end else if (w_sel == BANKSEL_PRG_FIRST) begin
                            n_prg_first = i_in.payload.data;
                        end else begin
                            n_prg_second = i_in.payload.data;
                        end
                    end
                    ADDR_MIRRORING: begin
                        if (!r_four_screen) n_mirror_h = i_in.payload.data[0];
                    end
                    ADDR_OUTER_BANK: begin
                        // game 7 folds onto game 6
                        n_outer_bank = (i_in.payload.data[2:0] == OUTER_INVALID) ?
                                       OUTER_WIDE : i_in.payload.data[2:0];
                    end
                    ADDR_IRQ_COUNT:  n_irq_count  = i_in.payload.data;
                    ADDR_IRQ_RELOAD: n_irq_reload = i_in.payload.data;
                    ADDR_IRQ_OFF:    n_irq_on     = 1'b0;
                    ADDR_IRQ_ON:     n_irq_on     = 1'b1;
                    default: ;
                endcase
            end else if (w_tick_counts) begin
                if (r_irq_count == 8'd0) begin
                    n_irq_count = r_irq_reload;
                    n_irq       = 1'b1;
                end else begin
                    n_irq_count = r_irq_count - 8'd1;
                end
            end
        end
    end

    // Bank mapping from the post-update state
    always_comb begin
        logic [6:0] prg_swap;
        logic [6:0] prg_fixed;
        logic [9:0] pairs   [4];
        logic [9:0] singles [4];
        logic [39:0] pair_word;
        logic [39:0] single_word;
        prg_swap  = prg_number(n_prg_first, n_outer_bank);
        prg_fixed = prg_number(PRG_SECOND_LAST, n_outer_bank);
        n_out.prg_banks[27:21] = prg_number(PRG_LAST, n_outer_bank);
        n_out.prg_banks[13:7]  = prg_number(n_prg_second, n_outer_bank);
        if (n_bank_select[BANK_SELECT_PRG_SWAP]) begin
            n_out.prg_banks[6:0]   = prg_fixed;
            n_out.prg_banks[20:14] = prg_swap;
        end else begin
            n_out.prg_banks[6:0]   = prg_swap;
            n_out.prg_banks[20:14] = prg_fixed;
        end

        pairs[0] = chr_number(n_chr_pair[0], n_outer_bank);
        pairs[1] = chr_number({n_chr_pair[0][7:1], 1'b1}, n_outer_bank);
        pairs[2] = chr_number(n_chr_pair[1], n_outer_bank);
        pairs[3] = chr_number({n_chr_pair[1][7:1], 1'b1}, n_outer_bank);
        for (int k = 0; k < 4; k++) begin
            singles[k] = chr_number(n_chr_single[k], n_outer_bank);
        end
        pair_word   = {pairs[3], pairs[2], pairs[1], pairs[0]};
        single_word = {singles[3], singles[2], singles[1], singles[0]};

        if (!r_chr_rom_present) begin
            n_out.chr_banks_low  = '0;
            n_out.chr_banks_high = '0;
        end else if (n_bank_select[BANK_SELECT_CHR_SWAP]) begin
            n_out.chr_banks_low  = single_word;
            n_out.chr_banks_high = pair_word;
        end else begin
            n_out.chr_banks_low  = pair_word;
            n_out.chr_banks_high = single_word;
        end

        n_out.mirroring   = r_four_screen ? MIRROR_FOUR :
                            (n_mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
        n_out.irq_request = n_irq;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_rom_present <= 1'b1;
            r_four_screen     <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_CHR_ROM_PRESENT: r_chr_rom_present <= i_cfg.data;
                CFG_FOUR_SCREEN:     r_four_screen     <= i_cfg.data;
            endcase
        end
    end

    // Mapper state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select   <= 8'd0;
            r_outer_bank    <= 3'd0;
            r_prg_first     <= 8'd0;
            r_prg_second    <= 8'd1;
            r_chr_pair[0]   <= 8'd0;
            r_chr_pair[1]   <= 8'd2;
            r_chr_single[0] <= 8'd4;
            r_chr_single[1] <= 8'd5;
            r_chr_single[2] <= 8'd6;
            r_chr_single[3] <= 8'd7;
            r_irq_count     <= 8'd0;
            r_irq_reload    <= 8'd0;
            r_irq_on        <= 1'b0;
            r_mirror_h      <= 1'b0;
        end else begin
            r_bank_select <= n_bank_select;
            r_outer_bank  <= n_outer_bank;
            r_prg_first   <= n_prg_first;
            r_prg_second  <= n_prg_second;
            r_chr_pair    <= n_chr_pair;
            r_chr_single  <= n_chr_single;
            r_irq_count   <= n_irq_count;
            r_irq_reload  <= n_irq_reload;
            r_irq_on      <= n_irq_on;
            r_mirror_h    <= n_mirror_h;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    `MMC3MC_ASSERT_SAME(a_outer_folded, 1'b1, r_outer_bank != OUTER_INVALID, "outer bank 7 stored")
    `MMC3MC_ASSERT_SAME(a_pair_even, 1'b1, !r_chr_pair[0][0] && !r_chr_pair[1][0], "odd CHR pair bank")
    `MMC3MC_ASSERT_NEXT(a_write_no_irq, w_in_acc && (i_in.payload.command == CMD_CPU_WRITE), !r_out.irq_request, "IRQ on CPU write")
    `MMC3MC_ASSERT_NEXT(a_irq_reloads, w_in_acc && n_irq, r_irq_count == $past(r_irq_reload), "IRQ without reload")
    `MMC3MC_ASSERT_NEXT(a_stall_holds, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out), "result changed while stalled")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for mmc3_multicart_bank_mapper. It sends directed and random CPU
// write and scanline tick beats, keeps a local model of the mapper state, and
// compares each result beat with it. Depends on mmc3mc_pkg, mmc3mc_if.sv and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmc3mc_pkg::*;

    logic i_clk;
    logic i_rst_n;

    mmc3mc_cfg_if    cfg_bus ();
    mmc3mc_item_if   item_bus ();
    mmc3mc_result_if result_bus ();

    mmc3_multicart_bank_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (item_bus),
        .o_out   (result_bus)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Mapper model state. Bank data registers are indexed by the low three
    // bits of bank select: 0-1 are the 2KB CHR pairs, 2-5 the 1KB singles.
    // ------------------------------------------------------------------
    logic       has_chr;
    logic       four_scr;
    logic [7:0] sel_q;
    logic [2:0] game_q;
    logic [7:0] prg_r6;
    logic [7:0] prg_r7;
    logic [7:0] chr_regs [0:5];
    logic [7:0] irq_cnt;
    logic [7:0] irq_rld;
    logic       irq_en;
    logic       mirror_h;

    t_result_item pending_maps [$];

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned beats_sent;
    int unsigned maps_checked;
    int unsigned irq_pulses;
    int unsigned mismatches;

    task automatic reset_model();
        has_chr   = 1'b1;
        four_scr  = 1'b0;
        sel_q     = 8'h00;
        game_q    = 3'd0;
        prg_r6    = 8'h00;
        prg_r7    = 8'h01;
        chr_regs  = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};
        irq_cnt   = 8'h00;
        irq_rld   = 8'h00;
        irq_en    = 1'b0;
        mirror_h  = 1'b0;
    endtask

    // Game select lands in bits 6:4; the wide game keeps five inner bits
    function automatic logic [6:0] prg_bank(input logic [7:0] inner);
        int m;
        m = (game_q == OUTER_WIDE) ? 'h1F : 'h0F;
        return 7'((int'(inner) & m) | (int'(game_q) << 4));
    endfunction

    // Game select lands in bits 9:7; the wide game keeps all eight inner bits
    function automatic logic [9:0] chr_bank(input int inner);
        int m;
        m = (game_q == OUTER_WIDE) ? 'hFF : 'h7F;
        return 10'((inner & m) | (int'(game_q) << 7));
    endfunction

    // Applies one beat to the model and returns the bank map that follows it
    task automatic predict_bank_map(input t_in_item beat, output t_result_item map);
        logic [6:0] prg  [4];
        logic [9:0] chr  [8];
        logic [9:0] pair [4];
        logic [9:0] solo [4];
        logic [7:0] d;
        d   = beat.data;
        map = '0;
        if (beat.command == CMD_CPU_WRITE) begin
            case (beat.address & ADDR_DECODE_MASK)
                ADDR_BANK_SELECT: sel_q = d;
                ADDR_BANK_DATA: begin
                    if (sel_q[2:0] <= BANKSEL_LAST_PAIR) begin
                        if (has_chr) chr_regs[sel_q[2:0]] = d & 8'hFE;
                    end else if (sel_q[2:0] <= BANKSEL_LAST_SINGLE) begin
                        if (has_chr) chr_regs[sel_q[2:0]] = d;
                    end else if (sel_q[2:0] == BANKSEL_PRG_FIRST) begin
                        prg_r6 = d;
                    end else begin
                        prg_r7 = d;
                    end
                end
                ADDR_MIRRORING: if (!four_scr) mirror_h = d[0];
                ADDR_OUTER_BANK: game_q = (d[2:0] == OUTER_INVALID) ? OUTER_WIDE : d[2:0];
                ADDR_IRQ_COUNT:  irq_cnt = d;
                ADDR_IRQ_RELOAD: irq_rld = d;
                ADDR_IRQ_OFF:    irq_en = 1'b0;
                ADDR_IRQ_ON:     irq_en = 1'b1;
                default: ;
            endcase
        end else if (irq_en && beat.scanline <= LAST_VISIBLE_LINE && beat.rendering) begin
            if (irq_cnt == 8'h00) begin
                irq_cnt = irq_rld;
                map.irq_request = 1'b1;
            end else begin
                irq_cnt = irq_cnt - 8'd1;
            end
        end

        prg[1] = prg_bank(prg_r7);
        prg[3] = prg_bank(PRG_LAST);
        if (sel_q[BANK_SELECT_PRG_SWAP]) begin
            prg[0] = prg_bank(PRG_SECOND_LAST);
            prg[2] = prg_bank(prg_r6);
        end else begin
            prg[0] = prg_bank(prg_r6);
            prg[2] = prg_bank(PRG_SECOND_LAST);
        end
        map.prg_banks = {prg[3], prg[2], prg[1], prg[0]};

        pair[0] = chr_bank(int'(chr_regs[0]));
        pair[1] = chr_bank(int'(chr_regs[0]) + 1);
        pair[2] = chr_bank(int'(chr_regs[1]));
        pair[3] = chr_bank(int'(chr_regs[1]) + 1);
        for (int i = 0; i < 4; i++) begin
            solo[i] = chr_bank(int'(chr_regs[i + 2]));
            if (sel_q[BANK_SELECT_CHR_SWAP]) begin
                chr[i]     = solo[i];
                chr[i + 4] = pair[i];
            end else begin
                chr[i]     = pair[i];
                chr[i + 4] = solo[i];
            end
        end
        if (has_chr) begin
            map.chr_banks_low  = {chr[3], chr[2], chr[1], chr[0]};
            map.chr_banks_high = {chr[7], chr[6], chr[5], chr[4]};
        end
        map.mirroring = four_scr ? MIRROR_FOUR :
                        (mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
    endtask

    // ------------------------------------------------------------------
    // Beat builders. Fields that the command ignores get random values.
    // ------------------------------------------------------------------
    function automatic t_in_item cpu_write_beat(input logic [15:0] addr, input logic [7:0] d);
        t_in_item b;
        b.command   = CMD_CPU_WRITE;
        b.address   = addr;
        b.data      = d;
        b.scanline  = 9'($urandom_range(0, 261));
        b.rendering = 1'($urandom);
        return b;
    endfunction

    function automatic t_in_item line_tick_beat(input logic [8:0] line, input logic rend);
        t_in_item b;
        b.command   = CMD_LINE_TICK;
        b.address   = 16'($urandom);
        b.data      = 8'($urandom);
        b.scanline  = line;
        b.rendering = rend;
        return b;
    endfunction

    // Mostly well-formed traffic: decoded register writes with random
    // don't-care address bits, and visible-line ticks with rendering on so the
    // IRQ counter keeps running. The rest is noise.
    function automatic t_in_item random_beat();
        int unsigned roll;
        logic [15:0] base;
        logic [7:0]  d;
        roll = $urandom_range(99);
        if (roll < 35) return line_tick_beat(9'($urandom_range(0, 239)), 1'b1);
        if (roll < 45) return line_tick_beat(9'($urandom_range(0, 261)), 1'($urandom));
        if (roll >= 90) return cpu_write_beat(16'($urandom), 8'($urandom));
        d = 8'($urandom);
        case ($urandom_range(0, 11))
            0:       base = ADDR_BANK_SELECT;
            1, 2, 3: base = ADDR_BANK_DATA;
            4:       base = ADDR_MIRRORING;
            5:       base = ADDR_OUTER_BANK;
            6:       base = ADDR_IRQ_COUNT;
            7:       base = ADDR_IRQ_RELOAD;
            8:       base = ADDR_IRQ_OFF;
            default: base = ADDR_IRQ_ON;
        endcase
        // short counts and reload values make IRQ pulses frequent
        if ((base == ADDR_IRQ_COUNT || base == ADDR_IRQ_RELOAD) && $urandom_range(99) < 70)
            d = 8'($urandom_range(0, 6));
        return cpu_write_beat(base | (16'($urandom) & ~ADDR_DECODE_MASK), d);
    endfunction

    // ------------------------------------------------------------------
    // Sender. valid is left high after a beat is taken, so a back-to-back
    // beat never sees valid dropped and raised in one time step.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_in_item beat);
        t_result_item want;
        while ($urandom_range(99) < tx_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= beat;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1) @(posedge i_clk);
        predict_bank_map(beat, want);
        pending_maps.push_back(want);
        beats_sent++;
    endtask

    // Stop sending and hold off until every expected map has come back
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_CHR_ROM_PRESENT: has_chr  = val;
            CFG_FOUR_SCREEN:     four_scr = val;
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic check_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch on map %0d: expected %h, got %h",
                         $realtime, name, maps_checked, want, got);
        end
    endtask

    always @(posedge i_clk) begin : score_maps
        t_result_item want;
        t_result_item got;
        if (i_rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            got = result_bus.payload;
            if (pending_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %h", $realtime, got);
            end else begin
                want = pending_maps.pop_front();
                check_field("prg_banks", 40'(want.prg_banks), 40'(got.prg_banks));
                check_field("chr_banks_low", want.chr_banks_low, got.chr_banks_low);
                check_field("chr_banks_high", want.chr_banks_high, got.chr_banks_high);
                check_field("mirroring", 40'(want.mirroring), 40'(got.mirroring));
                check_field("irq_request", 40'(want.irq_request), 40'(got.irq_request));
                if (got.irq_request === 1'b1) irq_pulses++;
                maps_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Reset map, plus writes below the register window that must be ignored
    task automatic test_reset_state();
        send_beat(line_tick_beat(9'd261, 1'b1));
        send_beat(cpu_write_beat(16'h7FFF, 8'hFF));
        send_beat(cpu_write_beat(16'h0000, 8'h00));
    endtask

    // The bank select, bank data, mirroring and outer bank decodes, aliased
    // addresses, both swap bits, the pair bank bit 0 clear, and the outer select of 7 folding to 6
    task automatic test_bank_registers();
        send_beat(cpu_write_beat(ADDR_BANK_SELECT, 8'h00));
        send_beat(cpu_write_beat(ADDR_BANK_DATA | 16'h1FFE, 8'hFF));
        send_beat(cpu_write_beat(ADDR_BANK_SELECT | 16'h1FFE, 8'hC7));
        send_beat(cpu_write_beat(ADDR_BANK_DATA, 8'hFF));
        send_beat(cpu_write_beat(ADDR_OUTER_BANK, 8'hFF));
        send_beat(cpu_write_beat(ADDR_MIRRORING | 16'h1FFE, 8'h01));
        send_beat(cpu_write_beat(ADDR_OUTER_BANK, 8'h05));
        send_beat(cpu_write_beat(ADDR_MIRRORING, 8'hFE));
    endtask

    // Reload on zero, count down, and the three no-count cases: off the
    // visible lines, rendering off, IRQ disabled
    task automatic test_irq_counter();
        send_beat(cpu_write_beat(ADDR_IRQ_RELOAD, 8'h01));
        send_beat(cpu_write_beat(ADDR_IRQ_COUNT, 8'h00));
        send_beat(cpu_write_beat(ADDR_IRQ_ON | 16'h1FFE, 8'h00));
        send_beat(line_tick_beat(9'd0, 1'b1));
        send_beat(line_tick_beat(9'd239, 1'b1));
        send_beat(line_tick_beat(9'd240, 1'b1));
        send_beat(line_tick_beat(9'd100, 1'b0));
        send_beat(line_tick_beat(9'd239, 1'b1));
        send_beat(cpu_write_beat(16'hFFFE, 8'hFF));
        send_beat(line_tick_beat(9'd10, 1'b1));
    endtask

    // No CHR ROM drops CHR writes and zeroes CHR banks; four-screen locks
    // the mirroring. Restoring both brings back the old CHR banks.
    task automatic test_cartridge_options();
        wait_idle();
        write_cfg(CFG_CHR_ROM_PRESENT, 1'b0);
        write_cfg(CFG_FOUR_SCREEN, 1'b1);
        send_beat(cpu_write_beat(ADDR_BANK_SELECT, 8'h02));
        send_beat(cpu_write_beat(ADDR_BANK_DATA, 8'h33));
        send_beat(cpu_write_beat(ADDR_MIRRORING, 8'h01));
        wait_idle();
        write_cfg(CFG_CHR_ROM_PRESENT, 1'b1);
        write_cfg(CFG_FOUR_SCREEN, 1'b0);
        send_beat(line_tick_beat(9'd261, 1'b0));
    endtask

    // One random phase: drain, retune the cartridge options and handshake
    // pressure, then stream random beats
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input logic chr, input logic four, input int n);
        wait_idle();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        write_cfg(CFG_CHR_ROM_PRESENT, chr);
        write_cfg(CFG_FOUR_SCREEN, four);
        repeat (n) send_beat(random_beat());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned drain_cycles;
        i_rst_n          <= 1'b0;
        item_bus.valid   <= 1'b0;
        item_bus.payload <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_CHR_ROM_PRESENT;
        cfg_bus.data     <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        beats_sent   = 0;
        maps_checked = 0;
        irq_pulses   = 0;
        mismatches   = 0;
        reset_model();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_bank_registers();
        test_irq_counter();
        test_cartridge_options();

        // idle mix per phase, with the option extremes spread across them
        test_random_traffic(0, 0, 1'b1, 1'b0, 270);
        test_random_traffic(51, 0, 1'b0, 1'b1, 270);
        test_random_traffic(0, 51, 1'b1, 1'b1, 270);
        test_random_traffic(13, 13, 1'b0, 1'b0, 270);

        // bounded drain, then a wait for any stray beat to show up
        item_bus.valid <= 1'b0;
        drain_cycles = 0;
        while (pending_maps.size() != 0 && drain_cycles < 1000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (pending_maps.size() != 0) begin
            $display("%0d expected maps never arrived", pending_maps.size());
            mismatches += pending_maps.size();
        end

        $display("Sent %0d beats (writes, ticks, noise) over four idle mixes and option sets;",
                 beats_sent);
        $display("checked %0d bank maps, %0d with an IRQ pulse, %0d mismatches.",
                 maps_checked, irq_pulses, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout: run did not finish");
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mmc3mc_pkg.sv
design/mmc3mc_if.sv
design/mmc3_multicart_bank_mapper.sv
tb/sv/tb.sv
